@@ design/wsp_pkg.sv @@
`timescale 1ns / 1ps
package wsp_pkg;
  typedef enum logic [2:0] {
    PH_RIFF = 3'd0,
    PH_HDR  = 3'd1,
    PH_FMT  = 3'd2,
    PH_SKIP = 3'd3,
    PH_DATA = 3'd4,
    PH_DONE = 3'd5,
    PH_ERR  = 3'd6
  } phase_t;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_TOO_SMALL   = 4'd1;
  localparam logic [3:0] ST_NOT_WAV     = 4'd2;
  localparam logic [3:0] ST_TRUNC_FMT   = 4'd3;
  localparam logic [3:0] ST_DATA_EARLY  = 4'd4;
  localparam logic [3:0] ST_BAD_FORMAT  = 4'd5;
  localparam logic [3:0] ST_ZERO_CHAN   = 4'd6;
  localparam logic [3:0] ST_BAD_FRAME   = 4'd7;
  localparam logic [3:0] ST_NO_FRAMES   = 4'd8;
  localparam logic [3:0] ST_BAD_DEPTH   = 4'd9;
  localparam logic [3:0] ST_NO_DATA     = 4'd10;

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;
  localparam logic [32:0] MIN_FILE_BYTES = 33'd44;
  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] FMT_FLOAT = 16'd3;

  // result item handed from the parser to the output stage
  typedef struct packed {
    logic [31:0] sample_bits;
    logic        sample_valid;
    logic        finished;
    logic [3:0]  status;
    logic [31:0] rate_found;
  } res_t;

  // exact int16 / 32768 as IEEE single
  function automatic logic [31:0] pcm_to_float(input logic [15:0] s);
    logic        sgn;
    logic [15:0] mag;
    logic [4:0]  msb;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [15:0] sh;
    sgn = s[15];
    mag = sgn ? (~s + 16'd1) : s;
    msb = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (mag[i]) msb = 5'(i);
    end
    sh = mag << (5'd15 - msb);
    man = {sh[14:0], 8'd0};
    ex = 8'(8'd112 + {3'd0, msb});
    if (mag == 16'd0) pcm_to_float = 32'd0;
    else pcm_to_float = {sgn, ex, man};
  endfunction

  // float magnitude compare: a > b, false if either is NaN
  function automatic logic mag_gt(input logic [30:0] a, input logic [30:0] b);
    logic a_nan;
    logic b_nan;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    mag_gt = !a_nan && !b_nan && (a > b);
  endfunction
endpackage

@@ design/wsp_frame.sv @@
`timescale 1ns / 1ps
module wsp_frame (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        clr,        // reset of frame state (end of file)
  input  logic        byte_en,    // data byte of a supported depth
  input  logic [7:0]  byte_in,
  input  logic        is_pcm,
  input  logic [15:0] channel_total,
  output logic        frame_done,
  output logic [31:0] frame_value
);
  import wsp_pkg::*;

  logic [1:0]  byte_in_sample_r, byte_in_sample_nxt;
  logic [23:0] sample_shift_r, sample_shift_nxt;
  logic [15:0] channel_index_r, channel_index_nxt;
  logic [31:0] best_value_r, best_value_nxt;
  logic [31:0] word;
  logic [31:0] v;
  logic [31:0] best_upd;
  logic        last_byte;
  logic [16:0] ch_inc;

  always_comb begin
    word = {byte_in, sample_shift_r};
    last_byte = is_pcm ? (byte_in_sample_r == 2'd1) : (byte_in_sample_r == 2'd3);
    v = is_pcm ? pcm_to_float({byte_in, sample_shift_r[7:0]}) : word;
    best_upd = mag_gt(v[30:0], best_value_r[30:0]) ? v : best_value_r;
    ch_inc = {1'b0, channel_index_r} + 17'd1;
    byte_in_sample_nxt = byte_in_sample_r;
    sample_shift_nxt = sample_shift_r;
    channel_index_nxt = channel_index_r;
    best_value_nxt = best_value_r;
    frame_done = 1'b0;
    frame_value = best_upd;
    if (byte_en) begin
      if (last_byte) begin
        byte_in_sample_nxt = 2'd0;
        sample_shift_nxt = 24'd0;
        if (ch_inc >= {1'b0, channel_total}) begin
          frame_done = 1'b1;
          best_value_nxt = 32'd0;
          channel_index_nxt = 16'd0;
        end else begin
          best_value_nxt = best_upd;
          channel_index_nxt = ch_inc[15:0];
        end
      end else begin
        case (byte_in_sample_r)
          2'd0: sample_shift_nxt[7:0] = byte_in;
          2'd1: sample_shift_nxt[15:8] = byte_in;
          default: sample_shift_nxt[23:16] = byte_in;
        endcase
        byte_in_sample_nxt = byte_in_sample_r + 2'd1;
      end
    end
    if (clr) begin
      byte_in_sample_nxt = 2'd0;
      sample_shift_nxt = 24'd0;
      channel_index_nxt = 16'd0;
      best_value_nxt = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_in_sample_r <= 2'd0;
      sample_shift_r <= 24'd0;
      channel_index_r <= 16'd0;
      best_value_r <= 32'd0;
    end else begin
      byte_in_sample_r <= byte_in_sample_nxt;
      sample_shift_r <= sample_shift_nxt;
      channel_index_r <= channel_index_nxt;
      best_value_r <= best_value_nxt;
    end
  end
endmodule

@@ design/wsp_parse.sv @@
`timescale 1ns / 1ps
module wsp_parse (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,       // one registered byte is processed
  input  logic [7:0]  byte_in,
  input  logic        eof,
  output logic        res_take,
  output wsp_pkg::res_t res
);
  import wsp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [32:0] byte_count_r, byte_count_nxt;
  logic [31:0] chunk_tag_r, chunk_tag_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [15:0] format_r, format_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [15:0] depth_r, depth_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic        fmt_seen_r, fmt_seen_nxt;
  logic        fcs_r, fcs_nxt;
  logic [3:0]  err_r, err_nxt;
  logic [2:0]  hdr_pos_r, hdr_pos_nxt;
  logic [3:0]  fmt_pos_r, fmt_pos_nxt;
  logic [31:0] odd_r, odd_nxt;

  logic        depth_ok, is_pcm, data_en, frame_done;
  logic [31:0] frame_value;
  logic [31:0] tag_sh;
  logic [32:0] size, rem_dec, pad;
  logic [31:0] frame_bytes;
  logic [32:0] odd_inc;
  logic [32:0] cnt_inc;
  logic [3:0]  st;

  assign depth_ok = (format_r == FMT_PCM && depth_r == 16'd16) ||
                    (format_r == FMT_FLOAT && depth_r == 16'd32);
  assign is_pcm = (format_r == FMT_PCM);
  assign data_en = step && (phase_r == PH_DATA) && depth_ok;
  assign frame_bytes = {16'd0, 3'd0, depth_r[15:3]} * {16'd0, chan_r};

  wsp_frame u_frame (
    .clk(clk), .rst_n(rst_n), .clr(step && eof), .byte_en(data_en),
    .byte_in(byte_in), .is_pcm(is_pcm), .channel_total(chan_r),
    .frame_done(frame_done), .frame_value(frame_value)
  );

  always_comb begin
    phase_nxt = phase_r; chunk_tag_nxt = chunk_tag_r; rem_nxt = rem_r;
    format_nxt = format_r; chan_nxt = chan_r; depth_nxt = depth_r; rate_nxt = rate_r;
    fmt_seen_nxt = fmt_seen_r; fcs_nxt = fcs_r; err_nxt = err_r;
    hdr_pos_nxt = hdr_pos_r; fmt_pos_nxt = fmt_pos_r; odd_nxt = odd_r;
    tag_sh = {chunk_tag_r[23:0], byte_in};
    rem_dec = rem_r - 33'd1;
    size = {byte_in[0], rem_r[31:0]};
    pad = size + {32'd0, size[0]};
    odd_inc = {1'b0, odd_r} + 33'd1;
    cnt_inc = byte_count_r + 33'd1;
    byte_count_nxt = (&byte_count_r) ? byte_count_r : cnt_inc;
    unique case (phase_r)
      PH_RIFF: begin
        chunk_tag_nxt = tag_sh;
        if (byte_count_r == 33'd3 && tag_sh != TAG_RIFF) begin
          err_nxt = ST_NOT_WAV; phase_nxt = PH_ERR;
        end else if (byte_count_r == 33'd11) begin
          if (tag_sh != TAG_WAVE) begin
            err_nxt = ST_NOT_WAV; phase_nxt = PH_ERR;
          end else begin
            phase_nxt = PH_HDR; hdr_pos_nxt = 3'd0;
          end
        end
      end
      PH_HDR: begin
        hdr_pos_nxt = hdr_pos_r + 3'd1;
        if (!hdr_pos_r[2]) begin
          chunk_tag_nxt = tag_sh;
          if (hdr_pos_r == 3'd0) rem_nxt = 33'd0;
        end else begin
          case (hdr_pos_r[1:0])
            2'd0: rem_nxt[7:0] = byte_in;
            2'd1: rem_nxt[15:8] = byte_in;
            2'd2: rem_nxt[23:16] = byte_in;
            default: rem_nxt[31:24] = byte_in;
          endcase
        end
        if (hdr_pos_r == 3'd7) begin
          hdr_pos_nxt = 3'd0;
          size = {1'b0, byte_in, rem_r[23:0]};
          pad = size + {32'd0, size[0]};
          if (chunk_tag_r == TAG_FMT) begin
            if (size < 33'd16) begin
              err_nxt = ST_TRUNC_FMT; phase_nxt = PH_ERR;
            end else begin
              fmt_pos_nxt = 4'd0; phase_nxt = PH_FMT; rem_nxt = size;
            end
          end else if (chunk_tag_r == TAG_DATA) begin
            rem_nxt = size;
            if (!fmt_seen_r) begin
              err_nxt = ST_DATA_EARLY; phase_nxt = PH_ERR;
            end else if (format_r != FMT_PCM && format_r != FMT_FLOAT) begin
              err_nxt = ST_BAD_FORMAT; phase_nxt = PH_ERR;
            end else if (chan_r == 16'd0) begin
              err_nxt = ST_ZERO_CHAN; phase_nxt = PH_ERR;
            end else if (frame_bytes == 32'd0) begin
              err_nxt = ST_BAD_FRAME; phase_nxt = PH_ERR;
            end else begin
              phase_nxt = (size == 33'd0) ? PH_DONE : PH_DATA;
            end
          end else begin
            rem_nxt = pad;
            phase_nxt = (pad == 33'd0) ? PH_HDR : PH_SKIP;
          end
        end
      end
      PH_FMT: begin
        case (fmt_pos_r)
          4'd0: format_nxt = {8'd0, byte_in};
          4'd1: format_nxt[15:8] = byte_in;
          4'd2: chan_nxt = {8'd0, byte_in};
          4'd3: chan_nxt[15:8] = byte_in;
          4'd4: rate_nxt = {24'd0, byte_in};
          4'd5: rate_nxt[15:8] = byte_in;
          4'd6: rate_nxt[23:16] = byte_in;
          4'd7: rate_nxt[31:24] = byte_in;
          4'd14: depth_nxt = {8'd0, byte_in};
          4'd15: depth_nxt[15:8] = byte_in;
          default: ;
        endcase
        fmt_pos_nxt = fmt_pos_r + 4'd1;
        if (fmt_pos_r == 4'd15) begin
          fmt_seen_nxt = 1'b1;
          rem_nxt = rem_r - 33'd16 + {32'd0, rem_r[0]};
          phase_nxt = (rem_nxt == 33'd0) ? PH_HDR : PH_SKIP;
          hdr_pos_nxt = 3'd0;
        end
      end
      PH_SKIP: begin
        rem_nxt = rem_dec;
        if (rem_dec == 33'd0) begin
          phase_nxt = PH_HDR; hdr_pos_nxt = 3'd0;
        end
      end
      PH_DATA: begin
        rem_nxt = rem_dec;
        if (depth_ok) begin
          if (frame_done) fcs_nxt = 1'b1;
        end else if (!fcs_r) begin
          odd_nxt = odd_inc[31:0];
          if (odd_inc >= {1'b0, frame_bytes}) fcs_nxt = 1'b1;
        end
        if (rem_dec == 33'd0) phase_nxt = PH_DONE;
      end
      default: ;
    endcase

    // status at end of file, from the post-byte state (saturated byte count)
    if (byte_count_nxt < MIN_FILE_BYTES) st = ST_TOO_SMALL;
    else if (err_nxt != ST_OK) st = err_nxt;
    else if (phase_nxt == PH_DATA || phase_nxt == PH_DONE)
      st = !fcs_nxt ? ST_NO_FRAMES : (!depth_ok ? ST_BAD_DEPTH : ST_OK);
    else if (phase_nxt == PH_FMT) st = ST_TRUNC_FMT;
    else st = ST_NO_DATA;

    res.sample_valid = data_en && frame_done;
    res.sample_bits = res.sample_valid ? frame_value : 32'd0;
    res.finished = eof;
    res.status = eof ? st : ST_OK;
    res.rate_found = (eof && st == ST_OK) ? rate_nxt : 32'd0;
    res_take = step && (res.sample_valid || eof);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && eof)) begin
      phase_r <= PH_RIFF; byte_count_r <= 33'd0; chunk_tag_r <= 32'd0; rem_r <= 33'd0;
      format_r <= 16'd0; chan_r <= 16'd0; depth_r <= 16'd0; rate_r <= 32'd0;
      fmt_seen_r <= 1'b0; fcs_r <= 1'b0; err_r <= ST_OK;
      hdr_pos_r <= 3'd0; fmt_pos_r <= 4'd0; odd_r <= 32'd0;
    end else if (step) begin
      phase_r <= phase_nxt; byte_count_r <= byte_count_nxt; chunk_tag_r <= chunk_tag_nxt;
      rem_r <= rem_nxt; format_r <= format_nxt; chan_r <= chan_nxt; depth_r <= depth_nxt;
      rate_r <= rate_nxt; fmt_seen_r <= fmt_seen_nxt; fcs_r <= fcs_nxt; err_r <= err_nxt;
      hdr_pos_r <= hdr_pos_nxt; fmt_pos_r <= fmt_pos_nxt; odd_r <= odd_nxt;
    end
  end
endmodule

@@ design/wav_stream_parse_mono.sv @@
`timescale 1ns / 1ps
// Byte-serial RIFF/WAVE parser with a mono IEEE-single sample output.
// Input channel (in_valid/in_ready): one file byte per item, in_end_of_file
//   on the last byte of a file. The next file starts on the following item.
// Output channel (out_valid/out_ready): one item per finished frame (largest
//   magnitude channel, PCM scaled by 1/32768) and one on the last byte carrying
//   finished, status and rate_found; both can come in the same item.
// Path: a byte is accepted into the input register, then passes through the parse
//   logic into the output register; a stall can hold it in the input register.
//   Throughput: one byte per cycle while the output is not stalled; the per-byte
//   decision logic and the frame compare sit in one stage.
// Stall: an item waits in the output register; the input register advances
//   into the parser only when the output register is free or being drained, so
//   in_ready drops while both registers hold items and out_ready is low.
// Reset: synchronous active-low rst_n returns to the RIFF header phase with
//   all format state cleared; no item pending on either side.
module wav_stream_parse_mono (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_file_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_sample_bits,
  output logic        out_sample_valid,
  output logic        out_finished,
  output logic [3:0]  out_status,
  output logic [31:0] out_rate_found
);
  import wsp_pkg::*;

  logic       ib_valid_r;
  logic [7:0] ib_byte_r;
  logic       ib_eof_r;
  logic       ob_valid_r;
  res_t       ob_r;
  res_t       res;
  logic       res_take;
  logic       step;

  // input byte moves into the parser when the output slot can take a result
  assign step = ib_valid_r && (!ob_valid_r || out_ready);
  assign in_ready = !ib_valid_r || step;

  wsp_parse u_parse (
    .clk(clk), .rst_n(rst_n), .step(step), .byte_in(ib_byte_r), .eof(ib_eof_r),
    .res_take(res_take), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ib_valid_r <= 1'b0;
      ob_valid_r <= 1'b0;
    end else begin
      if (in_ready) ib_valid_r <= in_valid;
      if (res_take) ob_valid_r <= 1'b1;
      else if (out_ready) ob_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ib_byte_r <= in_file_byte;
      ib_eof_r <= in_end_of_file;
    end
    if (res_take) ob_r <= res;
  end

  assign out_valid = ob_valid_r;
  assign out_sample_bits = ob_r.sample_bits;
  assign out_sample_valid = ob_r.sample_valid;
  assign out_finished = ob_r.finished;
  assign out_status = ob_r.status;
  assign out_rate_found = ob_r.rate_found;
endmodule
